// ===== rtl/core/sts_pkg.sv =====
// Shared constants for the sphere triangle index sequencer.
package sts_pkg;

   localparam int MAX_RINGS_DEF    = 256;
   localparam int MAX_SEGMENTS_DEF = 256;

   localparam int CFG_W    = 9;   // width of ring_count / segment_count
   localparam int IDX_W    = 17;  // vertex index and triangle number width
   localparam int CSR_ADDR_W = 1;

   localparam int REQ_DATA_W = 8;  // restart, padded to a byte
   localparam int RSP_DATA_W = 72; // 4 x 17 bits, padded to whole bytes

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_RING_COUNT    = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEGMENT_COUNT = 1'd1;

   localparam logic [CFG_W-1:0] RING_COUNT_RST    = 9'd1;
   localparam logic [CFG_W-1:0] SEGMENT_COUNT_RST = 9'd3;

endpackage

// ===== rtl/core/sphere_triangle_index_sequencer.sv =====
// Top level: UV-sphere triangle index stream, one triangle per request.
//
//  channel | direction | payload (lowest bit first)                     | accept
//  req_    | in        | tdata: restart                                 | tvalid & tready
//  rsp_    | out       | tdata: vertex_a, vertex_b, vertex_c, tri num   | tvalid & tready
//          |           | tlast: last triangle of the mesh               |
//  csr_    | in        | wr_en, addr (0 ring_count, 1 segment_count)    | wr_en
//
// One request per cycle; the result shows up in the output register the
// cycle after the request is taken. The walk state and index math sit between
// the request handshake and that register, a few adds and compares deep.
// req_tready is high while the output register is empty or being drained, so
// requests keep flowing as long as rsp_tready is high.
// Synchronous reset returns the walk to the first triangle with ring_count 1,
// segment_count 3; a csr write to either register also restarts the walk.
module sphere_triangle_index_sequencer
   import sts_pkg::*;
#(
   parameter int MAX_RINGS    = MAX_RINGS_DEF,
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] restart, rest zero
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [16:0] vertex_a, [33:17] vertex_b,
                                              // [50:34] vertex_c,
                                              // [67:51] triangle_number, rest zero
   output logic                  rsp_tlast,   // last triangle of the mesh
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wr_data
);

   localparam int RW = $clog2(MAX_RINGS + 1);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   // walk sections
   localparam logic [1:0] SEC_TOP    = 2'd0;
   localparam logic [1:0] SEC_RINGS  = 2'd1;
   localparam logic [1:0] SEC_BOTTOM = 2'd2;

   logic [CFG_W-1:0] ring_count_ff, segment_count_ff;
   logic [1:0]       section_ff, section_in;
   logic [RW-1:0]    ring_index_ff, ring_index_in;
   logic [CW-1:0]    column_ff, column_in;
   logic             second_half_ff, second_half_in;
   logic [IDX_W-1:0] ring_base_ff, ring_base_in;
   logic [IDX_W-1:0] tri_count_ff, tri_count_in;

   logic             rsp_valid_ff;
   logic [IDX_W-1:0] vertex_a_ff, vertex_b_ff, vertex_c_ff, tri_num_ff;
   logic             last_ff;

   logic             req_accept, restart, cfg_hit;
   logic [CFG_W-1:0] l_eff, m_eff;
   logic [IDX_W-1:0] m_x;

   // walk position after an optional restart
   logic [1:0]       sec;
   logic [RW-1:0]    ring_index;
   logic [CW-1:0]    col, col1, col_next;
   logic             half;
   logic [IDX_W-1:0] base, tri_count;
   logic             col_wrap;

   logic [IDX_W-1:0] vertex_a, vertex_b, vertex_c;
   logic             fin;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign restart    = req_tdata[0];
   assign cfg_hit    = csr_wr_en &&
                       (csr_addr == CSR_RING_COUNT || csr_addr == CSR_SEGMENT_COUNT);

   // clamp registers into their legal ranges
   always_comb begin
      l_eff = ring_count_ff;
      if (ring_count_ff == '0)
         l_eff = CFG_W'(1);
      else if (ring_count_ff > MAX_RINGS)
         l_eff = CFG_W'(MAX_RINGS);
      m_eff = segment_count_ff;
      if (segment_count_ff < 3)
         m_eff = CFG_W'(3);
      else if (segment_count_ff > MAX_SEGMENTS)
         m_eff = CFG_W'(MAX_SEGMENTS);
   end
   assign m_x = IDX_W'(m_eff);

   // index math for the current triangle
   always_comb begin
      sec        = restart ? SEC_TOP : section_ff;
      ring_index = restart ? '0 : ring_index_ff;
      half       = restart ? 1'b0 : second_half_ff;
      base       = restart ? IDX_W'(1) : ring_base_ff;
      tri_count  = restart ? '0 : tri_count_ff;
      col        = restart ? '0 : column_ff;
      if (col >= m_eff)
         col = '0;
      col_next = col + CW'(1);
      col_wrap = (col_next == m_eff);
      col1     = col_wrap ? '0 : col_next;

      fin = 1'b0;
      case (sec)
         SEC_RINGS: begin
            vertex_a = base + m_x + IDX_W'(col);
            if (!half) begin
               vertex_b = base + IDX_W'(col);
               vertex_c = base + IDX_W'(col1);
            end else begin
               vertex_b = base + IDX_W'(col1);
               vertex_c = base + m_x + IDX_W'(col1);
            end
         end
         SEC_BOTTOM: begin
            // ring_base points at the last ring here, so N-1 = base + M
            vertex_a = base + IDX_W'(col1);
            vertex_b = base + m_x;
            vertex_c = base + IDX_W'(col);
            fin      = col_wrap;
         end
         default: begin
            vertex_a = IDX_W'(col1) + IDX_W'(1);
            vertex_b = IDX_W'(col) + IDX_W'(1);
            vertex_c = '0;
         end
      endcase
   end

   // next walk position
   always_comb begin
      section_in     = sec;
      ring_index_in  = ring_index;
      column_in      = col_next;
      second_half_in = half;
      ring_base_in   = base;
      tri_count_in   = tri_count + IDX_W'(1);
      case (sec)
         SEC_RINGS: begin
            if (!half) begin
               second_half_in = 1'b1;
               column_in      = col;
            end else begin
               second_half_in = 1'b0;
               if (col_wrap) begin
                  column_in     = '0;
                  ring_index_in = ring_index + RW'(1);
                  ring_base_in  = base + m_x;
                  if (IDX_W'(ring_index_in) >= IDX_W'(l_eff) - IDX_W'(1))
                     section_in = SEC_BOTTOM;
               end
            end
         end
         SEC_BOTTOM: begin
            if (fin) begin
               section_in     = SEC_TOP;
               ring_index_in  = '0;
               column_in      = '0;
               second_half_in = 1'b0;
               ring_base_in   = IDX_W'(1);
               tri_count_in   = '0;
            end
         end
         default: begin
            if (col_wrap) begin
               column_in      = '0;
               ring_index_in  = '0;
               second_half_in = 1'b0;
               ring_base_in   = IDX_W'(1);
               section_in     = (l_eff > 1) ? SEC_RINGS : SEC_BOTTOM;
            end
         end
      endcase
   end

   // configuration and walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff    <= RING_COUNT_RST;
         segment_count_ff <= SEGMENT_COUNT_RST;
         section_ff       <= SEC_TOP;
         ring_index_ff    <= '0;
         column_ff        <= '0;
         second_half_ff   <= 1'b0;
         ring_base_ff     <= IDX_W'(1);
         tri_count_ff     <= '0;
      end else if (cfg_hit) begin
         if (csr_addr == CSR_RING_COUNT)
            ring_count_ff <= csr_wr_data;
         else
            segment_count_ff <= csr_wr_data;
         section_ff     <= SEC_TOP;
         ring_index_ff  <= '0;
         column_ff      <= '0;
         second_half_ff <= 1'b0;
         ring_base_ff   <= IDX_W'(1);
         tri_count_ff   <= '0;
      end else if (req_accept) begin
         section_ff     <= section_in;
         ring_index_ff  <= ring_index_in;
         column_ff      <= column_in;
         second_half_ff <= second_half_in;
         ring_base_ff   <= ring_base_in;
         tri_count_ff   <= tri_count_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (req_accept)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         vertex_a_ff <= vertex_a;
         vertex_b_ff <= vertex_b;
         vertex_c_ff <= vertex_c;
         tri_num_ff  <= tri_count;
         last_ff     <= fin;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 4*IDX_W)'(0),
                        tri_num_ff, vertex_c_ff, vertex_b_ff, vertex_a_ff};

   // a last triangle leaves the walk parked at its start
   a_last_parks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> section_ff == SEC_TOP && tri_count_ff == '0)
      else $error("walk not restarted after last triangle");

   // a restart request yields triangle zero
   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      req_accept && restart |=> tri_num_ff == '0 && vertex_c_ff == '0)
      else $error("restart did not emit the first triangle");

   // column stays inside the ring
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      column_ff < m_eff)
      else $error("column index out of range");

   // ring pairs only exist with more than one ring
   a_rings_need_pair: assert property (@(posedge clock) disable iff (reset)
      section_ff == SEC_RINGS |-> l_eff > 1)
      else $error("ring section with a single ring");

endmodule

// ===== bench/sts_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker: tracks csr writes and requests, predicts each triangle, compares responses.
module sts_result_checker
   import sts_pkg::*;
#(
   parameter int MAX_RINGS    = MAX_RINGS_DEF,
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] restart
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // vertex_a, vertex_b, vertex_c, triangle_number
   input  logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    results_checked,
   output int                    mesh_ends
);

   typedef enum logic [1:0] {
      SEC_TOP_FAN,
      SEC_RING_PAIRS,
      SEC_BOTTOM_FAN
   } mesh_section_type;

   typedef struct packed {
      logic [IDX_W-1:0] vertex_a;
      logic [IDX_W-1:0] vertex_b;
      logic [IDX_W-1:0] vertex_c;
      logic [IDX_W-1:0] tri_num;
      logic             last;
   } triangle_type;

   triangle_type triangles_due[$];

   logic [CFG_W-1:0] ring_count_q;
   logic [CFG_W-1:0] segment_count_q;
   mesh_section_type section_q;
   int unsigned      ring_idx_q;
   int unsigned      column_q;
   bit               second_half_q;
   int unsigned      ring_base_q;
   int unsigned      tri_count_q;
   int               reported;

   function automatic void restart_walk();
      section_q     = SEC_TOP_FAN;
      ring_idx_q    = 0;
      column_q      = 0;
      second_half_q = 1'b0;
      ring_base_q   = 1;
      tri_count_q   = 0;
   endfunction

   // Next triangle of the walk, then step the walk forward.
   task automatic predict_triangle(input logic restart, output triangle_type t);
      int unsigned l, m, n, c, c1, a, b, v, base;
      bit fin;
      l = (ring_count_q < 1) ? 1 : ((ring_count_q > MAX_RINGS) ? MAX_RINGS : ring_count_q);
      m = (segment_count_q < 3) ? 3 :
          ((segment_count_q > MAX_SEGMENTS) ? MAX_SEGMENTS : segment_count_q);
      n = 2 + l * m;
      fin = 1'b0;
      if (restart) restart_walk();
      c = (column_q >= m) ? 0 : column_q;
      c1 = (c + 1 == m) ? 0 : c + 1;
      base = ring_base_q;

      case (section_q)
         SEC_RING_PAIRS: begin
            a = base + m + c;
            if (!second_half_q) begin
               b = base + c;
               v = base + c1;
            end else begin
               b = base + c1;
               v = base + m + c1;
            end
         end
         SEC_BOTTOM_FAN: begin
            a = base + c1;
            b = n - 1;
            v = base + c;
            fin = (c + 1 == m);
         end
         default: begin
            a = c1 + 1;
            b = c + 1;
            v = 0;
         end
      endcase

      t.vertex_a = a[IDX_W-1:0];
      t.vertex_b = b[IDX_W-1:0];
      t.vertex_c = v[IDX_W-1:0];
      t.tri_num  = tri_count_q[IDX_W-1:0];
      t.last     = fin;

      case (section_q)
         SEC_RING_PAIRS: begin
            if (!second_half_q) begin
               second_half_q = 1'b1;
               column_q      = c;
            end else begin
               second_half_q = 1'b0;
               column_q      = c + 1;
               if (column_q == m) begin
                  column_q    = 0;
                  ring_idx_q  = ring_idx_q + 1;
                  ring_base_q = ring_base_q + m;
                  if (ring_idx_q >= l - 1) section_q = SEC_BOTTOM_FAN;
               end
            end
            tri_count_q = tri_count_q + 1;
         end
         SEC_BOTTOM_FAN: begin
            if (fin) begin
               restart_walk();
            end else begin
               column_q    = c + 1;
               tri_count_q = tri_count_q + 1;
            end
         end
         default: begin
            column_q = c + 1;
            if (column_q == m) begin
               column_q      = 0;
               ring_idx_q    = 0;
               second_half_q = 1'b0;
               ring_base_q   = 1;
               section_q     = (l > 1) ? SEC_RING_PAIRS : SEC_BOTTOM_FAN;
            end
            tri_count_q = tri_count_q + 1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      triangle_type want, got;
      if (reset) begin
         ring_count_q    = RING_COUNT_RST;
         segment_count_q = SEGMENT_COUNT_RST;
         restart_walk();
         triangles_due.delete();
         fail_count      = 0;
         results_checked = 0;
         mesh_ends       = 0;
         reported        = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_addr == CSR_RING_COUNT) begin
               ring_count_q = csr_wr_data;
               restart_walk();
            end else if (csr_addr == CSR_SEGMENT_COUNT) begin
               segment_count_q = csr_wr_data;
               restart_walk();
            end
         end

         // compare before queuing this edge's request
         if (rsp_tvalid && rsp_tready) begin
            got.vertex_a = rsp_tdata[16:0];
            got.vertex_b = rsp_tdata[33:17];
            got.vertex_c = rsp_tdata[50:34];
            got.tri_num  = rsp_tdata[67:51];
            got.last     = rsp_tlast;
            if (triangles_due.size() == 0) begin
               fail_count++;
               if (reported < 10)
                  $display("%0t: unexpected triangle (%0d,%0d,%0d) #%0d last=%0b", $realtime,
                           got.vertex_a, got.vertex_b, got.vertex_c, got.tri_num, got.last);
               reported++;
            end else begin
               want = triangles_due.pop_front();
               results_checked++;
               if (got.last) mesh_ends++;
               if (got.vertex_a !== want.vertex_a || got.vertex_b !== want.vertex_b ||
                   got.vertex_c !== want.vertex_c || got.tri_num !== want.tri_num ||
                   got.last !== want.last) begin
                  fail_count++;
                  if (reported < 10)
                     $display("%0t: triangle mismatch exp (%0d,%0d,%0d) #%0d last=%0b",
                              $realtime, want.vertex_a, want.vertex_b, want.vertex_c,
                              want.tri_num, want.last, "  got (%0d,%0d,%0d) #%0d last=%0b",
                              got.vertex_a, got.vertex_b, got.vertex_c, got.tri_num,
                              got.last);
                  reported++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            predict_triangle(req_tdata[0], want);
            triangles_due.push_back(want);
         end
      end
      pending = triangles_due.size();
   end

endmodule

// ===== bench/tb_sphere_triangle_index_sequencer.sv =====
`timescale 1ns / 1ps
// Testbench top: request, csr and backpressure stimulus for the sphere index sequencer.
module tb_sphere_triangle_index_sequencer;
   import sts_pkg::*;

   localparam int ITEM_TARGET  = 650;   // requests to send overall
   localparam int CALM_TAIL    = 80;    // last requests go without idle cycles
   localparam int LONG_HOLD    = 64;    // one long rsp_tready low stretch
   localparam int HOLD_AT      = 150;   // ... started once this many requests went in
   localparam int DRAIN_CYCLES = 2000;  // bound on the final wait for results

   // Edge settings walked first: zero and all-ones data, clamp bounds on both sides.
   localparam logic [4:0][CFG_W-1:0] EXTREME_RINGS = {9'd2, 9'd1, 9'd256, 9'd511, 9'd0};
   localparam logic [4:0][CFG_W-1:0] EXTREME_SEGS  = {9'd257, 9'd2, 9'd256, 9'd511, 9'd0};

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [0] restart, rest zero
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [16:0] vertex_a, [33:17] vertex_b, [50:34] vertex_c,
                                       // [67:51] triangle_number, rest zero
   logic                  rsp_tlast;   // last triangle of the mesh
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CFG_W-1:0]      csr_wr_data;

   int fail_count;
   int pending;
   int results_checked;
   int mesh_ends;

   int requests_sent;
   int settings_used;
   bit calm;                       // no idling on either side once set
   logic [CFG_W-1:0] cur_rings;    // register contents as last written
   logic [CFG_W-1:0] cur_segs;

   sphere_triangle_index_sequencer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   sts_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_wr_en       (csr_wr_en),
      .csr_addr        (csr_addr),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .mesh_ends       (mesh_ends)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop in case the handshake hangs.
   initial begin
      #2_000_000;
      $display("** sphere_triangle_index_sequencer: FAILED **");
      $finish;
   end

   // One request; entered and left at a falling edge. An optional idle burst
   // comes first, so tvalid drops only when a gap is really wanted.
   task automatic send_request(input logic restart);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      calm = (requests_sent >= ITEM_TARGET - CALM_TAIL);
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding triangle; a few spare
   // cycles cover the output register before the next csr write.
   task automatic end_burst();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Back-to-back csr writes keep wr_en high; it is lowered once afterwards.
   task automatic program_mesh(input bit wr_rings, input logic [CFG_W-1:0] rings,
                               input bit wr_segs, input logic [CFG_W-1:0] segs);
      if (wr_rings) begin
         csr_wr_en   <= 1'b1;
         csr_addr    <= CSR_RING_COUNT;
         csr_wr_data <= rings;
         cur_rings    = rings;
         @(negedge clock);
      end
      if (wr_segs) begin
         csr_wr_en   <= 1'b1;
         csr_addr    <= CSR_SEGMENT_COUNT;
         csr_wr_data <= segs;
         cur_segs     = segs;
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Result side: random stalls, one long hold-off to back the block up,
   // and full speed at the end.
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (!long_hold_done && requests_sent >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      int unsigned eff_l, eff_m, tris, items, restart_odds, k, waited;
      logic [CFG_W-1:0] rings, segs;
      bit wr_r, wr_s;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_wr_en     = 1'b0;
      csr_addr      = CSR_RING_COUNT;
      csr_wr_data   = '0;
      requests_sent = 0;
      settings_used = 0;
      calm          = 1'b0;
      cur_rings     = RING_COUNT_RST;
      cur_segs      = SEGMENT_COUNT_RST;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset mesh (one ring of three): top fan straight into the bottom fan,
      // last flag, wrap to the start, then an explicit restart.
      repeat (7) send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      end_burst();

      // Two rings: one ring pair between the fans, full pass plus a restart.
      program_mesh(1'b1, 9'd2, 1'b1, 9'd3);
      repeat (12) send_request(1'b0);
      send_request(1'b1);
      end_burst();

      // Random phases: clamp extremes first, then mostly small meshes that
      // complete and wrap, some random sizes, single-register rewrites that
      // cut a walk short, and occasional restart requests mid-mesh.
      k = 0;
      while (requests_sent < ITEM_TARGET) begin
         if (k < 5) begin
            rings = EXTREME_RINGS[k];
            segs  = EXTREME_SEGS[k];
            wr_r  = 1'b1;
            wr_s  = 1'b1;
         end else begin
            if ($urandom_range(0, 7) == 0) begin
               rings = CFG_W'($urandom_range(0, 511));
               segs  = CFG_W'($urandom_range(0, 511));
            end else begin
               rings = CFG_W'($urandom_range(1, 4));
               segs  = CFG_W'($urandom_range(3, 6));
            end
            wr_r = ($urandom_range(0, 3) != 0);
            wr_s = !wr_r || ($urandom_range(0, 1) == 1);
         end
         program_mesh(wr_r, rings, wr_s, segs);

         eff_l = (cur_rings < 1) ? 1 : ((cur_rings > MAX_RINGS_DEF) ? MAX_RINGS_DEF : cur_rings);
         eff_m = (cur_segs < 3) ? 3 :
                 ((cur_segs > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : cur_segs);
         tris  = 2 * eff_l * eff_m;
         items = (tris <= 80) ? tris + $urandom_range(1, 12) : $urandom_range(20, 60);
         restart_odds = ($urandom_range(0, 1) == 1) ? 0 : 8;

         repeat (items)
            send_request(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
         end_burst();
         k++;
      end

      // Final drain, bounded.
      waited = 0;
      while (pending != 0 && waited < DRAIN_CYCLES) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);

      $display("Run: %0d requests, %0d triangles checked, %0d mesh settings.",
               requests_sent, results_checked, settings_used);
      $display("Run: %0d complete meshes, %0d failures.", mesh_ends, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("** sphere_triangle_index_sequencer: PASSED **");
      end else begin
         $display("** sphere_triangle_index_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
